// ----- src/lzsd_pkg.sv -----
// Shared types and constants for the LZ77 stream decompressor.
`default_nettype none
package lzsd_pkg;
    localparam int WIN_DEPTH   = 4096;
    localparam int WIN_AW      = 12;
    localparam int SIZE_BITS   = 24;
    localparam int LEN_W       = 5;
    localparam int LEN_BIAS    = 3;
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = 2;

    typedef enum logic [2:0] {
        F_IDLE,
        F_HEADER,
        F_FLAG,
        F_TOKEN,
        F_SECOND
    } t_front_phase;

    typedef enum logic [1:0] {
        B_IDLE,
        B_READ,
        B_EMIT
    } t_back_state;

    // One decoded command: a literal byte or a copy from the history window
    typedef struct packed {
        logic             is_copy;
        logic [3:0]       disp_hi;
        logic [7:0]       lo;          // literal byte, or low byte of displacement
        logic [LEN_W-1:0] count;       // bytes to produce, 1..18
        logic             stream_last; // its final byte ends the stream
    } t_cmd;
endpackage
`default_nettype wire

// ----- src/lzsd_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module lzsd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  wire                      i_clk,
    input  wire                      i_we,
    input  wire  [$clog2(DEPTH)-1:0] i_waddr,
    input  wire  [WIDTH-1:0]         i_wdata,
    input  wire                      i_re,
    input  wire  [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end
endmodule
`default_nettype wire

// ----- src/lzsd_front.sv -----
// Front end: parses header, flag bytes and tokens into commands.
`default_nettype none
module lzsd_front (
    input  wire           i_clk,
    input  wire           i_rst_n,
    input  wire           i_valid,
    input  wire           i_start,
    input  wire  [7:0]    i_byte,
    output logic          o_ready,
    input  wire           i_full,
    output logic          o_push,
    output lzsd_pkg::t_cmd o_cmd
);
    import lzsd_pkg::*;

    t_front_phase          r_phase, n_phase;
    logic [1:0]            r_hcnt, n_hcnt;
    logic [SIZE_BITS-1:0]  r_rem, n_rem;
    logic [7:0]            r_flags, n_flags;
    logic [2:0]            r_fpos, n_fpos;
    logic [7:0]            r_first, n_first;
    logic                  w_acc;
    logic [LEN_W-1:0]      w_len;
    logic [LEN_W-1:0]      w_n;

    assign o_ready = !i_full;
    assign w_acc   = i_valid && !i_full;
    assign w_len   = LEN_W'(r_first[7:4]) + LEN_W'(LEN_BIAS);
    assign w_n     = (r_rem < SIZE_BITS'(w_len)) ? r_rem[LEN_W-1:0] : w_len;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= F_IDLE;
            r_hcnt  <= '0;
            r_rem   <= '0;
            r_flags <= '0;
            r_fpos  <= 3'd7;
            r_first <= '0;
        end else begin
            r_phase <= n_phase;
            r_hcnt  <= n_hcnt;
            r_rem   <= n_rem;
            r_flags <= n_flags;
            r_fpos  <= n_fpos;
            r_first <= n_first;
        end
    end

    always_comb begin
        n_phase = r_phase;
        n_hcnt  = r_hcnt;
        n_rem   = r_rem;
        n_flags = r_flags;
        n_fpos  = r_fpos;
        n_first = r_first;
        o_push  = 1'b0;
        o_cmd   = '0;
        if (w_acc) begin
            if (i_start) begin
                n_phase = F_HEADER;
                n_hcnt  = 2'd1;
                n_rem   = '0;
            end else begin
                case (r_phase)
                    F_HEADER: begin
                        case (r_hcnt)
                            2'd2: n_rem = r_rem | (SIZE_BITS'(i_byte) << 8);
                            2'd3: n_rem = r_rem | (SIZE_BITS'(i_byte) << 16);
                            default: n_rem = r_rem | SIZE_BITS'(i_byte);
                        endcase
                        if (r_hcnt == 2'd3) begin
                            n_hcnt  = 2'd0;
                            n_phase = (n_rem != '0) ? F_FLAG : F_IDLE;
                        end else if (r_hcnt == 2'd0) begin
                            n_hcnt = 2'd2;
                        end else begin
                            n_hcnt = r_hcnt + 2'd1;
                        end
                    end
                    F_FLAG: begin
                        n_flags = i_byte;
                        n_fpos  = 3'd7;
                        n_phase = F_TOKEN;
                    end
                    F_TOKEN: begin
                        if (r_flags[r_fpos]) begin
                            n_first = i_byte;
                            n_phase = F_SECOND;
                        end else begin
                            o_push            = 1'b1;
                            o_cmd.lo          = i_byte;
                            o_cmd.count       = LEN_W'(1);
                            o_cmd.stream_last = (r_rem == SIZE_BITS'(1));
                            n_rem             = r_rem - SIZE_BITS'(1);
                            if (n_rem == '0) begin
                                n_phase = F_IDLE;
                            end else if (r_fpos == 3'd0) begin
                                n_phase = F_FLAG;
                            end else begin
                                n_fpos  = r_fpos - 3'd1;
                                n_phase = F_TOKEN;
                            end
                        end
                    end
                    F_SECOND: begin
                        o_push            = 1'b1;
                        o_cmd.is_copy     = 1'b1;
                        o_cmd.disp_hi     = r_first[3:0];
                        o_cmd.lo          = i_byte;
                        o_cmd.count       = w_n;
                        n_rem             = r_rem - SIZE_BITS'(w_n);
                        o_cmd.stream_last = (n_rem == '0);
                        if (n_rem == '0) begin
                            n_phase = F_IDLE;
                        end else if (r_fpos == 3'd0) begin
                            n_phase = F_FLAG;
                        end else begin
                            n_fpos  = r_fpos - 3'd1;
                            n_phase = F_TOKEN;
                        end
                    end
                    default: n_phase = F_IDLE;
                endcase
            end
        end
    end
endmodule
`default_nettype wire

// ----- src/lzsd_queue.sv -----
// Short command queue between front and back end.
`default_nettype none
module lzsd_queue (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_push,
    input  wire lzsd_pkg::t_cmd i_cmd,
    output logic                o_full,
    input  wire                 i_pop,
    output lzsd_pkg::t_cmd      o_cmd,
    output logic                o_empty
);
    import lzsd_pkg::*;

    t_cmd                r_mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] r_wp, r_rp;
    logic [QUEUE_AW:0]   r_cnt;

    assign o_full  = (r_cnt == (QUEUE_AW+1)'(QUEUE_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_cmd   = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= r_wp + QUEUE_AW'(1);
            if (i_pop)  r_rp <= r_rp + QUEUE_AW'(1);
            case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + (QUEUE_AW+1)'(1);
                2'b01:   r_cnt <= r_cnt - (QUEUE_AW+1)'(1);
                default: r_cnt <= r_cnt;
            endcase
        end
    end
endmodule
`default_nettype wire

// ----- src/lzsd_back.sv -----
// Back end: executes commands through the history window, drives output beats.
`default_nettype none
module lzsd_back (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_empty,
    input  wire lzsd_pkg::t_cmd i_cmd,
    output logic                o_pop,
    output logic                o_valid,
    input  wire                 i_ready,
    output logic [7:0]          o_byte,
    output logic                o_last,
    output logic                o_end
);
    import lzsd_pkg::*;

    t_back_state        r_state, n_state;
    logic [WIN_AW-1:0]  r_wp, n_wp;
    logic [WIN_AW-1:0]  r_disp, n_disp;
    logic [LEN_W-1:0]   r_cnt, n_cnt;
    logic               r_slast, n_slast;
    logic               r_ovalid, n_ovalid;
    logic [7:0]         r_obyte, n_obyte;
    logic               r_olast, n_olast;
    logic               r_oend, n_oend;
    logic               w_can_load;
    logic               w_we, w_re;
    logic [7:0]         w_wdata, w_rdata;
    logic [WIN_AW-1:0]  w_raddr;

    assign w_can_load = !r_ovalid || i_ready;
    assign w_raddr    = r_wp - r_disp - WIN_AW'(1);
    assign o_valid    = r_ovalid;
    assign o_byte     = r_obyte;
    assign o_last     = r_olast;
    assign o_end      = r_oend;

    lzsd_ram #(.WIDTH(8), .DEPTH(WIN_DEPTH)) u_window (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (r_wp),
        .i_wdata (w_wdata),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= B_IDLE;
            r_wp     <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_wp     <= n_wp;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_disp  <= n_disp;
        r_cnt   <= n_cnt;
        r_slast <= n_slast;
        r_obyte <= n_obyte;
        r_olast <= n_olast;
        r_oend  <= n_oend;
    end

    always_comb begin
        n_state  = r_state;
        n_wp     = r_wp;
        n_disp   = r_disp;
        n_cnt    = r_cnt;
        n_slast  = r_slast;
        n_ovalid = r_ovalid && !i_ready;
        n_obyte  = r_obyte;
        n_olast  = r_olast;
        n_oend   = r_oend;
        o_pop    = 1'b0;
        w_we     = 1'b0;
        w_re     = 1'b0;
        w_wdata  = i_cmd.lo;
        case (r_state)
            B_IDLE: begin
                if (!i_empty) begin
                    if (i_cmd.is_copy) begin
                        o_pop   = 1'b1;
                        n_disp  = {i_cmd.disp_hi, i_cmd.lo};
                        n_cnt   = i_cmd.count;
                        n_slast = i_cmd.stream_last;
                        n_state = B_READ;
                    end else if (w_can_load) begin
                        // literal: store and emit in one go
                        o_pop    = 1'b1;
                        w_we     = 1'b1;
                        n_wp     = r_wp + WIN_AW'(1);
                        n_ovalid = 1'b1;
                        n_obyte  = i_cmd.lo;
                        n_olast  = 1'b1;
                        n_oend   = i_cmd.stream_last;
                    end
                end
            end
            B_READ: begin
                w_re    = 1'b1;
                n_state = B_EMIT;
            end
            B_EMIT: begin
                w_wdata = w_rdata;
                if (w_can_load) begin
                    w_we     = 1'b1;
                    n_wp     = r_wp + WIN_AW'(1);
                    n_ovalid = 1'b1;
                    n_obyte  = w_rdata;
                    n_olast  = (r_cnt == LEN_W'(1));
                    n_oend   = (r_cnt == LEN_W'(1)) && r_slast;
                    n_cnt    = r_cnt - LEN_W'(1);
                    n_state  = (r_cnt == LEN_W'(1)) ? B_IDLE : B_READ;
                end
            end
            default: n_state = B_IDLE;
        endcase
    end
endmodule
`default_nettype wire

// ----- src/lz77_stream_decompressor.sv -----
// Top level of the LZ77 stream decompressor.
`default_nettype none
// LZ77 decompressor with a 4 KiB history window, taking one compressed byte
// per input beat. Set tuser on the first header byte to start a stream; the
// header gives the output size, then flag bytes and tokens follow. A literal
// token is stored and emitted directly by the back end; a back-reference is
// taken as a command and then each output byte passes a window read state,
// then a write and emit state that waits on output back-pressure. This
// read-then-write loop through the single window RAM sets the rate. The front
// end accepts a beat each cycle while its four-entry command queue has room,
// so parsing runs ahead of the copy engine. Output tlast marks the last byte
// produced by one token, tuser the final byte of the stream. Bytes from
// references reaching before any written window data are unspecified.
module lz77_stream_decompressor (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    input  wire  [7:0]  s_axis_tdata,  // [7:0] in_byte
    input  wire         s_axis_tuser,  // [0] start_req
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    output logic [7:0]  m_axis_tdata,  // [7:0] out_byte
    output logic        m_axis_tlast,  // run_last
    output logic        m_axis_tuser   // [0] stream_end
);
    import lzsd_pkg::*;

    t_cmd w_push_cmd, w_head_cmd;
    logic w_push, w_full, w_pop, w_empty;

    // Parse beats into literal and copy commands
    lzsd_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .i_start (s_axis_tuser),
        .i_byte  (s_axis_tdata),
        .o_ready (s_axis_tready),
        .i_full  (w_full),
        .o_push  (w_push),
        .o_cmd   (w_push_cmd)
    );

    // Hold commands so either side can stall independently
    lzsd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cmd   (w_push_cmd),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_cmd   (w_head_cmd),
        .o_empty (w_empty)
    );

    // Expand commands through the window into output beats
    lzsd_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_empty (w_empty),
        .i_cmd   (w_head_cmd),
        .o_pop   (w_pop),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_byte  (m_axis_tdata),
        .o_last  (m_axis_tlast),
        .o_end   (m_axis_tuser)
    );
endmodule
`default_nettype wire
